### rtl/core/modbus_rtu_frame_receiver_defines.svh
// assertion macros for the modbus rtu frame receiver
`ifndef MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define MRFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MRFR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MRFR_ASSERT(label, prop, msg)
`define MRFR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/core/mrfr_pkg.sv
// shared types and constants of the modbus rtu frame receiver
package mrfr_pkg;

	localparam int BUFFER_DEPTH_DEF = 256;
	localparam int LEN_W = 9;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [15:0] CRC_START = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_ACCEPTED   = 3'd1,
		ST_WRONG_ADDR = 3'd2,
		ST_BAD_CRC    = 3'd3,
		ST_TOO_SHORT  = 3'd4,
		ST_DROPPED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] gap_limit;
		logic [7:0] silence_limit;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic             ready;
		logic [LEN_W-1:0] length;
		logic             receiving;
	} res_t;

endpackage

### rtl/core/mrfr_buffer.sv
// frame byte buffer, one write port and one registered read port
module mrfr_buffer #(
	parameter int DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/mrfr_ctrl.sv
// frame state, timers, running crc and buffer write control
module mrfr_ctrl #(
	parameter int DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  mrfr_pkg::cmd_t     command,
	input  logic [7:0]         data,
	input  mrfr_pkg::cfg_t     cfg,
	input  logic               restart,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [7:0]         wdata,
	output mrfr_pkg::res_t     res
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] MIN_FRAME = CW'(4);

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ mrfr_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic           in_frame_q, in_frame_n;
	logic [CW-1:0]  count_q, count_n;
	logic [8:0]     gap_q, gap_n, gap_inc;
	logic           gap_on_q, gap_on_n;
	logic [7:0]     sil_q, sil_n, sil_inc;
	logic           sil_on_q, sil_on_n;
	logic [15:0]    crc_q, crc_n, crc_new;
	logic           ready_q, ready_n;
	logic [7:0]     addr_byte_q, addr_byte_n;
	mrfr_pkg::status_t status;

	assign crc_new = crc_add(in_frame_q ? crc_q : mrfr_pkg::CRC_START, data);
	assign gap_inc = gap_q + 9'd1;
	assign sil_inc = sil_q + 8'd1;

	always_comb begin
		in_frame_n = in_frame_q;
		count_n = count_q;
		gap_n = gap_q;
		gap_on_n = gap_on_q;
		sil_n = sil_q;
		sil_on_n = sil_on_q;
		crc_n = crc_q;
		ready_n = ready_q;
		addr_byte_n = addr_byte_q;
		status = mrfr_pkg::ST_NONE;
		we = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = data;
		if (restart) begin
			in_frame_n = 1'b0;
			count_n = '0;
			gap_n = '0;
			gap_on_n = 1'b0;
			sil_n = '0;
			sil_on_n = 1'b0;
			crc_n = mrfr_pkg::CRC_START;
			ready_n = 1'b0;
		end else if (accept) begin
			unique case (command)
				mrfr_pkg::CMD_BYTE: begin
					if (!in_frame_q) begin
						in_frame_n = 1'b1;
						we = 1'b1;
						waddr = '0;
						count_n = CW'(1);
						crc_n = crc_new;
						addr_byte_n = data;
						gap_n = '0;
						gap_on_n = 1'b1;
						sil_n = '0;
						sil_on_n = 1'b1;
						ready_n = 1'b0;
					end else if (gap_q <= {1'b0, cfg.gap_limit} && count_q < DEPTH_C) begin
						we = 1'b1;
						count_n = count_q + CW'(1);
						crc_n = crc_new;
						gap_n = '0;
						gap_on_n = 1'b1;
						sil_n = '0;
						sil_on_n = 1'b1;
					end else begin
						in_frame_n = 1'b0;
						gap_n = '0;
						gap_on_n = 1'b0;
						sil_n = '0;
						sil_on_n = 1'b0;
						ready_n = 1'b0;
						status = mrfr_pkg::ST_DROPPED;
					end
				end
				mrfr_pkg::CMD_TICK: begin
					if (gap_on_q) begin
						gap_n = gap_inc;
						if (gap_inc > {1'b0, cfg.gap_limit}) begin
							gap_on_n = 1'b0;
						end
					end
					if (sil_on_q) begin
						sil_n = sil_inc;
						if (sil_inc >= cfg.silence_limit) begin
							sil_on_n = 1'b0;
							sil_n = '0;
							in_frame_n = 1'b0;
							priority if (count_q < MIN_FRAME) begin
								status = mrfr_pkg::ST_TOO_SHORT;
							end else if (addr_byte_q != cfg.device_address) begin
								status = mrfr_pkg::ST_WRONG_ADDR;
							end else if (crc_q != 16'd0) begin
								status = mrfr_pkg::ST_BAD_CRC;
							end else begin
								ready_n = 1'b1;
								status = mrfr_pkg::ST_ACCEPTED;
							end
						end
					end
				end
				mrfr_pkg::CMD_READ, mrfr_pkg::CMD_NONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q <= '0;
			gap_q <= '0;
			gap_on_q <= 1'b0;
			sil_q <= '0;
			sil_on_q <= 1'b0;
			crc_q <= mrfr_pkg::CRC_START;
			ready_q <= 1'b0;
		end else begin
			in_frame_q <= in_frame_n;
			count_q <= count_n;
			gap_q <= gap_n;
			gap_on_q <= gap_on_n;
			sil_q <= sil_n;
			sil_on_q <= sil_on_n;
			crc_q <= crc_n;
			ready_q <= ready_n;
		end
	end

	always_ff @(posedge clk) begin
		addr_byte_q <= addr_byte_n;
	end

	always_comb begin
		res.status = status;
		res.ready = ready_n;
		res.length = mrfr_pkg::LEN_W'(count_n);
		res.receiving = in_frame_n;
	end

endmodule

### rtl/core/modbus_rtu_frame_receiver.sv
// top level of the modbus rtu frame receiver
//
// channel   direction  handshake            payload
// in        to block   in_valid/in_ready    command, data, index
// out       from block out_valid/out_ready  frame_status, frame_ready, frame_length,
//                                           read_data, receiving
// cfg       to block   apb write, pready=1  device_address, gap_limit, silence_limit
//
// one item per cycle while in_ready is high; the read stage and the buffer read port
// load at the transfer edge and the output register loads from them once the output
// is free; state updates, crc and buffer write happen in the transfer cycle
// reset clears the control state except the latched address byte; the buffer is not cleared and needs no sweep
// a stalled output holds the result; one more item is taken into the read stage
module modbus_rtu_frame_receiver #(
	parameter int BUFFER_DEPTH = mrfr_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    data,
	input  logic [7:0]                    index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    frame_status,
	output logic                          frame_ready,
	output logic [mrfr_pkg::LEN_W-1:0]    frame_length,
	output logic [7:0]                    read_data,
	output logic                          receiving,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mrfr_pkg::PADDR_W-1:0]  paddr,
	input  logic [mrfr_pkg::PDATA_W-1:0]  pwdata,
	output logic [mrfr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	`include "modbus_rtu_frame_receiver_defines.svh"

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_GAP_LIMIT = 2'd1;
	localparam logic [1:0] REG_SILENCE_LIMIT = 2'd2;

	mrfr_pkg::cfg_t cfg_q;
	logic           cfg_wr;
	logic [1:0]     reg_sel;
	logic           restart;

	logic           accept;
	logic           out_free;
	mrfr_pkg::cmd_t cmd;
	logic           rd_en;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic [7:0]     mem_rdata;
	mrfr_pkg::res_t res;

	logic           s1_valid_s1;
	mrfr_pkg::res_t res_s1;
	logic           rd_s1;

	logic           out_valid_q;
	mrfr_pkg::res_t out_res_q;
	logic [7:0]     out_rdata_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign restart = cfg_wr && (reg_sel == REG_DEVICE_ADDRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= 8'd1;
			cfg_q.gap_limit <= 8'd3;
			cfg_q.silence_limit <= 8'd7;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= pwdata[7:0];
				REG_GAP_LIMIT:      cfg_q.gap_limit <= pwdata[7:0];
				REG_SILENCE_LIMIT:  cfg_q.silence_limit <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_q.device_address};
			REG_GAP_LIMIT:      prdata = {24'd0, cfg_q.gap_limit};
			REG_SILENCE_LIMIT:  prdata = {24'd0, cfg_q.silence_limit};
			default:            prdata = '0;
		endcase
	end

	// transfer and read issue
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_s1 || out_free;
	assign accept = in_valid && in_ready;
	assign cmd = mrfr_pkg::cmd_t'(command);
	assign rd_en = accept && (cmd == mrfr_pkg::CMD_READ)
		&& ({1'b0, index} < 9'(BUFFER_DEPTH));

	mrfr_ctrl #(
		.DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(cmd),
		.data(data),
		.cfg(cfg_q),
		.restart(restart),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.res(res)
	);

	mrfr_buffer #(
		.DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_buffer (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(rd_en),
		.raddr(index[AW-1:0]),
		.rdata(mem_rdata)
	);

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (out_free) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			rd_s1 <= rd_en;
		end
		if (s1_valid_s1 && out_free) begin
			out_res_q <= res_s1;
			out_rdata_q <= rd_s1 ? mem_rdata : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_status = out_res_q.status;
	assign frame_ready = out_res_q.ready;
	assign frame_length = out_res_q.length;
	assign read_data = out_rdata_q;
	assign receiving = out_res_q.receiving;

	`MRFR_ASSERT(a_s1_hold, s1_valid_s1 && !out_free |=> s1_valid_s1 && $stable(mem_rdata), "read stage lost its item while stalled")
	`MRFR_ASSERT(a_accept_sets_ready, out_valid && (frame_status == mrfr_pkg::ST_ACCEPTED) |-> frame_ready, "accepted frame without ready flag")
	`MRFR_ASSERT(a_length_bound, out_valid |-> (frame_length <= mrfr_pkg::LEN_W'(BUFFER_DEPTH)), "frame length beyond buffer depth")
	`MRFR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_length), "output changed while stalled")

endmodule
